>>> rtl/core/bary_pkg.sv
// Shared types and constants for the barycentric coordinate pipeline.
// No dependencies.
package bary_pkg;

  localparam int DET_THR_W  = 63;
  localparam int EDGE_THR_W = 32;
  localparam int CFG_DATA_W = 63;

  localparam logic REG_DET_THR  = 1'b0;
  localparam logic REG_EDGE_THR = 1'b1;

  localparam logic [DET_THR_W-1:0]  DET_THR_RESET  = 63'd4295;
  localparam logic [EDGE_THR_W-1:0] EDGE_THR_RESET = 32'd1;

  localparam logic [1:0] CASE_NORMAL = 2'd0;
  localparam logic [1:0] CASE_AB     = 2'd1;
  localparam logic [1:0] CASE_AC     = 2'd2;
  localparam logic [1:0] CASE_SHORT  = 2'd3;

  typedef struct packed {
    logic valid;
    logic deg;
    logic ab;
    logic short_edge;
  } side_t;

endpackage

>>> rtl/core/barycentric_coordinates.sv
// Barycentric weights of a point against a 3D triangle, fully pipelined, one item per cycle.
// The pipeline has seven arithmetic stages (edge differences, component products, dot sums,
// Gram products, determinant and numerators, degenerate tests, divider operand select), then
// one divider stage per quotient bit, then the output register. The whole pipeline advances
// together whenever the output register is empty or being taken, so throughput is one item
// per cycle without backpressure. Weights are signed with WEIGHT_FRAC_BITS fraction bits and
// saturate; case_code tells normal, degenerate along AB, degenerate along AC, or a too-short
// edge (t = 0.5). Uses bary_pkg and bary_div.
module barycentric_coordinates #(
  parameter int COORD_WIDTH      = 16,
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_en,
  input  logic cfg_index,
  input  logic [bary_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [COORD_WIDTH-1:0] a_x,
  input  logic signed [COORD_WIDTH-1:0] a_y,
  input  logic signed [COORD_WIDTH-1:0] a_z,
  input  logic signed [COORD_WIDTH-1:0] b_x,
  input  logic signed [COORD_WIDTH-1:0] b_y,
  input  logic signed [COORD_WIDTH-1:0] b_z,
  input  logic signed [COORD_WIDTH-1:0] c_x,
  input  logic signed [COORD_WIDTH-1:0] c_y,
  input  logic signed [COORD_WIDTH-1:0] c_z,
  input  logic signed [COORD_WIDTH-1:0] p_x,
  input  logic signed [COORD_WIDTH-1:0] p_y,
  input  logic signed [COORD_WIDTH-1:0] p_z,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [WEIGHT_FRAC_BITS+8:0] weight_a,
  output logic signed [WEIGHT_FRAC_BITS+8:0] weight_b,
  output logic signed [WEIGHT_FRAC_BITS+8:0] weight_c,
  output logic [1:0] case_code
);

  localparam int WW   = WEIGHT_FRAC_BITS + 9;
  localparam int QW   = WW + 1;
  localparam int DFW  = COORD_WIDTH + 1;
  localparam int PW   = 2 * COORD_WIDTH + 2;
  localparam int DTW  = 2 * COORD_WIDTH + 4;
  localparam int MW   = 2 * DTW;
  localparam int NBW  = 4 * COORD_WIDTH + 9;
  localparam int DENW = 4 * COORD_WIDTH + 8;
  localparam int NW   = NBW + WEIGHT_FRAC_BITS;
  localparam int CMPW = (DENW > bary_pkg::DET_THR_W) ? DENW : bary_pkg::DET_THR_W;
  localparam int LW   = (DTW > bary_pkg::EDGE_THR_W) ? DTW : bary_pkg::EDGE_THR_W;
  localparam int SW   = WW + 2;
  localparam logic signed [SW-1:0] S_ONE  = SW'(1) << WEIGHT_FRAC_BITS;
  localparam logic signed [SW-1:0] S_MAX  = SW'((SW'(1) << (WW - 1)) - SW'(1));
  localparam logic signed [SW-1:0] S_MIN  = -(SW'(1) << (WW - 1));
  localparam logic signed [WW-1:0] W_HALF = WW'(1) << (WEIGHT_FRAC_BITS - 1);

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // configuration
  logic [bary_pkg::DET_THR_W-1:0]  det_thr;
  logic [bary_pkg::EDGE_THR_W-1:0] edge_thr;

  always_ff @(posedge clk) begin
    if (rst) begin
      det_thr  <= bary_pkg::DET_THR_RESET;
      edge_thr <= bary_pkg::EDGE_THR_RESET;
    end else if (cfg_en) begin
      case (cfg_index)
        bary_pkg::REG_DET_THR:  det_thr  <= cfg_data[bary_pkg::DET_THR_W-1:0];
        bary_pkg::REG_EDGE_THR: edge_thr <= cfg_data[bary_pkg::EDGE_THR_W-1:0];
        default: ;
      endcase
    end
  end

  // valid bits of stages 1..7
  logic [6:0] v;

  always_ff @(posedge clk) begin
    if (rst) v <= '0;
    else if (en) v <= {v[5:0], in_valid};
  end

  // stage 1: edge vectors
  logic signed [DFW-1:0] e0 [3];
  logic signed [DFW-1:0] e1 [3];
  logic signed [DFW-1:0] qv [3];

  always_ff @(posedge clk) begin
    if (en) begin
      e0[0] <= DFW'(b_x) - DFW'(a_x);
      e0[1] <= DFW'(b_y) - DFW'(a_y);
      e0[2] <= DFW'(b_z) - DFW'(a_z);
      e1[0] <= DFW'(c_x) - DFW'(a_x);
      e1[1] <= DFW'(c_y) - DFW'(a_y);
      e1[2] <= DFW'(c_z) - DFW'(a_z);
      qv[0] <= DFW'(p_x) - DFW'(a_x);
      qv[1] <= DFW'(p_y) - DFW'(a_y);
      qv[2] <= DFW'(p_z) - DFW'(a_z);
    end
  end

  // stage 2: component products
  logic signed [PW-1:0] m00 [3];
  logic signed [PW-1:0] m01 [3];
  logic signed [PW-1:0] m11 [3];
  logic signed [PW-1:0] m20 [3];
  logic signed [PW-1:0] m21 [3];

  for (genvar k = 0; k < 3; k++) begin : g_comp
    always_ff @(posedge clk) begin
      if (en) begin
        m00[k] <= PW'(e0[k]) * PW'(e0[k]);
        m01[k] <= PW'(e0[k]) * PW'(e1[k]);
        m11[k] <= PW'(e1[k]) * PW'(e1[k]);
        m20[k] <= PW'(qv[k]) * PW'(e0[k]);
        m21[k] <= PW'(qv[k]) * PW'(e1[k]);
      end
    end
  end

  // stage 3: dot products
  logic signed [DTW-1:0] d00, d01, d11, d20, d21;

  always_ff @(posedge clk) begin
    if (en) begin
      d00 <= DTW'(m00[0]) + DTW'(m00[1]) + DTW'(m00[2]);
      d01 <= DTW'(m01[0]) + DTW'(m01[1]) + DTW'(m01[2]);
      d11 <= DTW'(m11[0]) + DTW'(m11[1]) + DTW'(m11[2]);
      d20 <= DTW'(m20[0]) + DTW'(m20[1]) + DTW'(m20[2]);
      d21 <= DTW'(m21[0]) + DTW'(m21[1]) + DTW'(m21[2]);
    end
  end

  // stage 4: Gram products
  logic signed [MW-1:0] pd0, pd1, pb0, pb1, pc0, pc1;
  logic signed [DTW-1:0] d00_4, d11_4, d20_4, d21_4;

  always_ff @(posedge clk) begin
    if (en) begin
      pd0   <= MW'(d00) * MW'(d11);
      pd1   <= MW'(d01) * MW'(d01);
      pb0   <= MW'(d11) * MW'(d20);
      pb1   <= MW'(d01) * MW'(d21);
      pc0   <= MW'(d00) * MW'(d21);
      pc1   <= MW'(d01) * MW'(d20);
      d00_4 <= d00;
      d11_4 <= d11;
      d20_4 <= d20;
      d21_4 <= d21;
    end
  end

  // stage 5: determinant and numerators
  logic signed [NBW-1:0] det, nb, nc;
  logic signed [DTW-1:0] d00_5, d11_5, d20_5, d21_5;

  always_ff @(posedge clk) begin
    if (en) begin
      det   <= NBW'(pd0) - NBW'(pd1);
      nb    <= NBW'(pb0) - NBW'(pb1);
      nc    <= NBW'(pc0) - NBW'(pc1);
      d00_5 <= d00_4;
      d11_5 <= d11_4;
      d20_5 <= d20_4;
      d21_5 <= d21_4;
    end
  end

  // stage 6: degenerate test, edge choice, magnitudes
  logic [DENW-1:0] det_u;
  logic            deg_6, ab_6, nb_neg, nc_neg, ln_neg;
  logic [NBW-1:0]  nb_mag, nc_mag;
  logic [DTW-1:0]  len_6, ln_mag;
  logic            ab_c;
  logic signed [DTW-1:0] lnum_c;

  assign ab_c   = d00_5 > d11_5;
  assign lnum_c = ab_c ? d20_5 : d21_5;

  always_ff @(posedge clk) begin
    if (en) begin
      det_u  <= det[DENW-1:0];
      deg_6  <= (det == '0) || (CMPW'(det[DENW-1:0]) < CMPW'(det_thr));
      ab_6   <= ab_c;
      len_6  <= ab_c ? d00_5 : d11_5;
      ln_neg <= lnum_c[DTW-1];
      ln_mag <= lnum_c[DTW-1] ? DTW'(-lnum_c) : lnum_c;
      nb_neg <= nb[NBW-1];
      nb_mag <= nb[NBW-1] ? NBW'(-nb) : nb;
      nc_neg <= nc[NBW-1];
      nc_mag <= nc[NBW-1] ? NBW'(-nc) : nc;
    end
  end

  // stage 7: divider operands
  logic [NW-1:0]   num_b, num_c;
  logic [DENW-1:0] den_b, den_c;
  logic            neg_b, neg_c;
  logic            deg_7, ab_7, short_7;
  bary_pkg::side_t side_7;

  always_ff @(posedge clk) begin
    if (en) begin
      if (deg_6) begin
        num_b <= NW'(ln_mag) << WEIGHT_FRAC_BITS;
        den_b <= DENW'(len_6);
        neg_b <= ln_neg;
      end else begin
        num_b <= {nb_mag, {WEIGHT_FRAC_BITS{1'b0}}};
        den_b <= det_u;
        neg_b <= nb_neg;
      end
      num_c   <= {nc_mag, {WEIGHT_FRAC_BITS{1'b0}}};
      den_c   <= det_u;
      neg_c   <= nc_neg;
      deg_7   <= deg_6;
      ab_7    <= ab_6;
      short_7 <= (len_6 == '0) || (LW'(len_6) < LW'(edge_thr));
    end
  end

  assign side_7 = {v[6], deg_7, ab_7, short_7};

  // dividers and matching sideband line
  logic signed [WW-1:0] qb, qc;

  bary_div #(.NW(NW), .DENW(DENW), .WW(WW)) u_div_b (
    .clk(clk), .en(en), .num_mag(num_b), .num_neg(neg_b), .den(den_b), .quo(qb)
  );

  bary_div #(.NW(NW), .DENW(DENW), .WW(WW)) u_div_c (
    .clk(clk), .en(en), .num_mag(num_c), .num_neg(neg_c), .den(den_c), .quo(qc)
  );

  bary_pkg::side_t side [QW];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < QW; j++) side[j] <= '0;
    end else if (en) begin
      side[0] <= side_7;
      for (int j = 1; j < QW; j++) side[j] <= side[j-1];
    end
  end

  // output stage
  bary_pkg::side_t sd;
  logic signed [WW-1:0] t, wb_n, wc_n;
  logic signed [SW-1:0] wa_w;
  logic signed [WW-1:0] wa_n;
  logic [1:0]           code_n;

  assign sd = side[QW-1];

  always_comb begin
    t = sd.short_edge ? W_HALF : qb;
    if (sd.deg) begin
      wb_n = sd.ab ? t : '0;
      wc_n = sd.ab ? '0 : t;
      if (sd.short_edge) code_n = bary_pkg::CASE_SHORT;
      else if (sd.ab) code_n = bary_pkg::CASE_AB;
      else code_n = bary_pkg::CASE_AC;
    end else begin
      wb_n   = qb;
      wc_n   = qc;
      code_n = bary_pkg::CASE_NORMAL;
    end
    wa_w = S_ONE - SW'(wb_n) - SW'(wc_n);
    if (wa_w > S_MAX) wa_n = S_MAX[WW-1:0];
    else if (wa_w < S_MIN) wa_n = S_MIN[WW-1:0];
    else wa_n = wa_w[WW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= sd.valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      weight_a  <= wa_n;
      weight_b  <= wb_n;
      weight_c  <= wc_n;
      case_code <= code_n;
    end
  end

  // checks
  a_ab_c_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && case_code == bary_pkg::CASE_AB |-> weight_c == '0)
    else $error("AB case with nonzero weight_c");

  a_ac_b_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && case_code == bary_pkg::CASE_AC |-> weight_b == '0)
    else $error("AC case with nonzero weight_b");

  a_short_half : assert property (@(posedge clk) disable iff (rst)
    out_valid && case_code == bary_pkg::CASE_SHORT |->
      weight_a == W_HALF && (weight_b == W_HALF || weight_c == W_HALF))
    else $error("short edge item without half weights");

endmodule

>>> rtl/core/bary_div.sv
// Pipelined restoring divider, one quotient bit per stage, saturated signed result.
// Standalone; used by barycentric_coordinates.
module bary_div #(
  parameter int NW   = 89,
  parameter int DENW = 72,
  parameter int WW   = 25
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [NW-1:0]        num_mag,
  input  logic                 num_neg,
  input  logic [DENW-1:0]      den,
  output logic signed [WW-1:0] quo
);

  localparam int QW = WW + 1;
  localparam logic [QW-1:0] QHALF = {2'b01, {(WW-1){1'b0}}};
  localparam logic [QW-1:0] QMAX  = QHALF - QW'(1);
  localparam logic signed [WW-1:0] WMAX = {1'b0, {(WW-1){1'b1}}};
  localparam logic signed [WW-1:0] WMIN = {1'b1, {(WW-1){1'b0}}};

  logic [DENW-1:0] r     [QW];
  logic [QW-1:0]   lo    [QW];
  logic [QW-1:0]   q     [QW];
  logic [DENW-1:0] dn    [QW];
  logic            neg   [QW];
  logic            ovf   [QW];
  logic [DENW:0]   trial [QW];
  logic [DENW-1:0] den_s [QW];
  logic            ge    [QW];

  genvar i;
  for (i = 0; i < QW; i++) begin : g_step
    if (i == 0) begin : g_first
      assign trial[i] = {DENW'(num_mag >> QW), num_mag[QW-1]};
      assign den_s[i] = den;
      assign ge[i]    = trial[i] >= {1'b0, den_s[i]};
      always_ff @(posedge clk) begin
        if (en) begin
          dn[i]  <= den;
          neg[i] <= num_neg;
          ovf[i] <= (num_mag >> QW) >= NW'(den);
          lo[i]  <= {num_mag[QW-2:0], 1'b0};
          q[i]   <= {{(QW-1){1'b0}}, ge[i]};
          r[i]   <= ge[i] ? DENW'(trial[i] - {1'b0, den_s[i]}) : DENW'(trial[i]);
        end
      end
    end else begin : g_next
      assign trial[i] = {r[i-1], lo[i-1][QW-1]};
      assign den_s[i] = dn[i-1];
      assign ge[i]    = trial[i] >= {1'b0, den_s[i]};
      always_ff @(posedge clk) begin
        if (en) begin
          dn[i]  <= dn[i-1];
          neg[i] <= neg[i-1];
          ovf[i] <= ovf[i-1];
          lo[i]  <= {lo[i-1][QW-2:0], 1'b0};
          q[i]   <= {q[i-1][QW-2:0], ge[i]};
          r[i]   <= ge[i] ? DENW'(trial[i] - {1'b0, den_s[i]}) : DENW'(trial[i]);
        end
      end
    end
  end

  logic [QW-1:0] qf;
  logic [QW-1:0] qneg;

  assign qf   = q[QW-1];
  assign qneg = QW'(0) - qf;

  always_comb begin
    if (neg[QW-1]) begin
      if (ovf[QW-1] || qf > QHALF) quo = WMIN;
      else quo = qneg[WW-1:0];
    end else begin
      if (ovf[QW-1] || qf > QMAX) quo = WMAX;
      else quo = qf[WW-1:0];
    end
  end

endmodule
